/* sv/tprp_pkg.sv */
// Shared types and constants for the tracker pattern row parser.
// Used by the front, back and top-level modules; no dependencies.
package tprp_pkg;

    typedef enum logic [2:0] {
        OP_ROW_END,
        OP_HEADER,
        OP_MASK,
        OP_NOTE,
        OP_INSTR,
        OP_VOLC,
        OP_EFFECT,
        OP_PARAM
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic [6:0]  chan;
        logic [7:0]  data;
        logic        done;
        logic [3:0]  mask_upper;
    } op_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  channel;
        logic [7:0]  note;
        logic [7:0]  instrument;
        logic [7:0]  volume_command;
        logic [7:0]  effect_code;
        logic [7:0]  effect_param;
        logic [3:0]  event_bits;
        logic [3:0]  mask_upper;
        logic [31:0] row_update_mask;
        logic        channel_out_of_range;
    } res_t;

    typedef struct packed {
        logic [7:0] instrument_count;
        logic       start_on_new_instrument;
    } cfg_t;

    localparam logic [6:0] HDR_CHAN_BITS = 7'h7F;
    localparam logic [7:0] KEY_CUT       = 8'd254;
    localparam logic [7:0] KEY_OFF       = 8'd255;

    localparam logic [3:0] EV_CUT     = 4'b0001;
    localparam logic [3:0] EV_OFF     = 4'b0010;
    localparam logic [3:0] EV_START   = 4'b0100;
    localparam logic [3:0] EV_NEWINST = 4'b1000;

endpackage

/* sv/tprp_fifo.sv */
// Small first-word-fall-through queue of packed words.
// Generic; no package dependency.
module tprp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_MAX);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/tprp_front.sv */
// Front end: walks the byte stream, tracks the parse phase and field masks,
// and turns every accepted byte into one operation. Depends on tprp_pkg.
module tprp_front import tprp_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] pattern_byte,
    output op_t        op
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MASK,
        PH_NOTE,
        PH_INSTR,
        PH_VOLC,
        PH_EFFECT,
        PH_PARAM,
        PH_DONE
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [6:0] chan_reg, chan_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] fmask_reg [CHANNELS];

    logic       fm_we;
    logic [6:0] hdr_chan;
    logic       hdr_ok;
    logic       cur_ok;
    logic [7:0] stored_mask;
    phase_t     nph;

    function automatic phase_t next_phase(input logic [7:0] m, input phase_t from);
        phase_t p;
        if (from < PH_NOTE && m[0])
            p = PH_NOTE;
        else if (from < PH_INSTR && m[1])
            p = PH_INSTR;
        else if (from < PH_VOLC && m[2])
            p = PH_VOLC;
        else if (from < PH_EFFECT && m[3])
            p = PH_EFFECT;
        else if (from == PH_EFFECT)
            p = PH_PARAM;
        else
            p = PH_DONE;
        return p;
    endfunction

    assign hdr_chan    = (pattern_byte[6:0] & HDR_CHAN_BITS) - 7'd1;
    assign hdr_ok      = hdr_chan < CH_LIMIT;
    assign cur_ok      = chan_reg < CH_LIMIT;
    assign stored_mask = hdr_ok ? fmask_reg[hdr_chan[IDX_W-1:0]] : 8'd0;

    always_comb
    begin
        phase_next     = phase_reg;
        chan_next      = chan_reg;
        mask_next      = mask_reg;
        fm_we          = 1'b0;
        nph            = PH_DONE;
        op.code        = OP_MASK;
        op.chan        = chan_reg;
        op.data        = pattern_byte;
        op.done        = 1'b0;
        op.mask_upper  = mask_reg[7:4];
        case (phase_reg)
            PH_HEADER:
            begin
                if ((pattern_byte[6:0] & HDR_CHAN_BITS) == 7'd0)
                begin
                    op.code = OP_ROW_END;
                    op.done = 1'b1;
                    nph     = PH_HEADER;
                end
                else
                begin
                    op.code   = OP_HEADER;
                    op.chan   = hdr_chan;
                    chan_next = hdr_chan;
                    if (pattern_byte[7])
                    begin
                        nph = PH_MASK;
                    end
                    else
                    begin
                        mask_next     = stored_mask;
                        op.mask_upper = stored_mask[7:4];
                        nph           = next_phase(stored_mask, PH_MASK);
                    end
                end
            end
            PH_MASK:
            begin
                mask_next     = pattern_byte;
                fm_we         = cur_ok;
                op.mask_upper = pattern_byte[7:4];
                nph           = next_phase(pattern_byte, PH_MASK);
            end
            PH_NOTE:
            begin
                op.code = OP_NOTE;
                nph     = next_phase(mask_reg, PH_NOTE);
            end
            PH_INSTR:
            begin
                op.code = OP_INSTR;
                nph     = next_phase(mask_reg, PH_INSTR);
            end
            PH_VOLC:
            begin
                op.code = OP_VOLC;
                nph     = next_phase(mask_reg, PH_VOLC);
            end
            PH_EFFECT:
            begin
                op.code = OP_EFFECT;
                nph     = next_phase(mask_reg, PH_EFFECT);
            end
            PH_PARAM:
            begin
                op.code = OP_PARAM;
                nph     = PH_DONE;
            end
            default:
            begin
                nph = PH_HEADER;
            end
        endcase
        if (nph == PH_DONE)
        begin
            op.done    = (phase_reg != PH_DONE);
            phase_next = PH_HEADER;
        end
        else
        begin
            phase_next = nph;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            chan_reg  <= '0;
            mask_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                fmask_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            mask_reg  <= mask_next;
            if (fm_we)
            begin
                fmask_reg[chan_reg[IDX_W-1:0]] <= pattern_byte;
            end
        end
    end

endmodule

/* sv/tprp_back.sv */
// Back end: applies queued operations to the per-channel stores and builds
// one result for each completed entry or row end. Depends on tprp_pkg.
module tprp_back import tprp_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  op_t  op,
    input  logic op_valid,
    input  logic res_full,
    output logic op_pop,
    output logic res_push,
    output res_t res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    logic [7:0]  note_reg   [CHANNELS];
    logic [7:0]  inst_reg   [CHANNELS];
    logic [7:0]  volc_reg   [CHANNELS];
    logic [7:0]  effect_reg [CHANNELS];
    logic [7:0]  param_reg  [CHANNELS];
    logic [3:0]  pend_reg, pend_next;
    logic [31:0] touched_reg, touched_next;

    logic [IDX_W-1:0] idx;
    logic             ok;
    logic [7:0]       inst_val;
    logic [7:0]       note_v, inst_v, volc_v, effect_v, param_v;
    logic             we_note, we_inst, we_volc, we_effect, we_param;

    assign idx      = op.chan[IDX_W-1:0];
    assign ok       = op.chan < CH_LIMIT;
    assign op_pop   = op_valid && !res_full;
    assign res_push = op_pop && op.done;
    assign inst_val = (op.data > cfg.instrument_count) ? 8'd0 : op.data;

    always_comb
    begin
        pend_next    = pend_reg;
        touched_next = touched_reg;
        we_note      = 1'b0;
        we_inst      = 1'b0;
        we_volc      = 1'b0;
        we_effect    = 1'b0;
        we_param     = 1'b0;
        case (op.code)
            OP_ROW_END:
            begin
                touched_next = '0;
            end
            OP_HEADER:
            begin
                pend_next = '0;
                if (ok)
                begin
                    touched_next = touched_reg | (32'd1 << op.chan[4:0]);
                end
            end
            OP_NOTE:
            begin
                if (op.data == KEY_CUT)
                    pend_next = pend_reg | EV_CUT;
                else if (op.data == KEY_OFF)
                    pend_next = pend_reg | EV_OFF;
                else
                    we_note = ok;
            end
            OP_INSTR:
            begin
                if (((pend_reg & (EV_CUT | EV_OFF)) == 4'd0) && ok)
                begin
                    we_inst = 1'b1;
                    if (inst_reg[idx] != inst_val)
                    begin
                        pend_next = pend_reg | EV_NEWINST
                                  | (cfg.start_on_new_instrument ? EV_START : 4'd0);
                    end
                end
            end
            OP_VOLC:   we_volc   = ok;
            OP_EFFECT: we_effect = ok;
            OP_PARAM:  we_param  = ok;
            default:
            begin
            end
        endcase

        note_v   = we_note   ? op.data  : note_reg[idx];
        inst_v   = we_inst   ? inst_val : inst_reg[idx];
        volc_v   = we_volc   ? op.data  : volc_reg[idx];
        effect_v = we_effect ? op.data  : effect_reg[idx];
        param_v  = we_param  ? op.data  : param_reg[idx];

        res = '0;
        if (op.code == OP_ROW_END)
        begin
            res.kind            = 1'b1;
            res.row_update_mask = touched_reg;
        end
        else
        begin
            res.channel              = op.chan;
            res.event_bits           = pend_next;
            res.mask_upper           = op.mask_upper;
            res.channel_out_of_range = !ok;
            if (ok)
            begin
                res.note           = note_v;
                res.instrument     = inst_v;
                res.volume_command = volc_v;
                res.effect_code    = effect_v;
                res.effect_param   = param_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            touched_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                note_reg[i]   <= '0;
                inst_reg[i]   <= '0;
                volc_reg[i]   <= '0;
                effect_reg[i] <= '0;
                param_reg[i]  <= '0;
            end
        end
        else if (op_pop)
        begin
            pend_reg    <= pend_next;
            touched_reg <= touched_next;
            if (we_note)
                note_reg[idx] <= op.data;
            if (we_inst)
                inst_reg[idx] <= inst_val;
            if (we_volc)
                volc_reg[idx] <= op.data;
            if (we_effect)
                effect_reg[idx] <= op.data;
            if (we_param)
                param_reg[idx] <= op.data;
        end
    end

endmodule

/* sv/tracker_pattern_row_parser_core.sv */
// Top level of the tracker pattern row parser: APB register file, front end,
// operation queue, back end and result queue. Depends on tprp_pkg, tprp_fifo,
// tprp_front and tprp_back.
//
// Usage: bytes of the compressed pattern stream enter on pattern_byte, one
// beat when push is high and full is low. Each header, mask and field byte
// is classified by the front end and queued as one operation; the back end
// applies it to the per-channel stores and, when an entry or a row is
// complete, writes one result into a two-deep result queue. The oldest
// result is shown while empty is low and leaves on pop.
// Throughput: one byte per cycle while full is low, set by the single store
// access the back end makes per operation. A completing byte is registered
// as an operation in the operation queue, and its result in the result
// queue, before the result appears.
// If the receiver stops popping, the result queue fills, the back end
// holds, then the operation queue fills and full rises; nothing is lost.
// Reset clears all channel stores, masks and queues at once; no sweep.
// Registers: 0x0 instrument_count, 0x4 start_on_new_instrument; write only
// while the stream is idle.
module tracker_pattern_row_parser_core import tprp_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pattern_byte,
    input  logic        pop,
    output logic        empty,
    output logic        kind,
    output logic [6:0]  channel,
    output logic [7:0]  note,
    output logic [7:0]  instrument,
    output logic [7:0]  volume_command,
    output logic [7:0]  effect_code,
    output logic [7:0]  effect_param,
    output logic [3:0]  event_bits,
    output logic [3:0]  mask_upper,
    output logic [31:0] row_update_mask,
    output logic        channel_out_of_range
);

    localparam logic REG_INSTRUMENT_COUNT = 1'b0;
    localparam logic REG_START_MODE       = 1'b1;

    cfg_t cfg_reg;
    logic cfg_we;
    logic take;
    op_t  front_op;
    op_t  queued_op;
    logic op_empty;
    logic op_pop;
    logic res_full;
    logic res_push;
    res_t back_res;
    res_t out_res;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_INSTRUMENT_COUNT: prdata = {24'd0, cfg_reg.instrument_count};
            REG_START_MODE:       prdata = {31'd0, cfg_reg.start_on_new_instrument};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_INSTRUMENT_COUNT: cfg_reg.instrument_count <= pwdata[7:0];
                REG_START_MODE:       cfg_reg.start_on_new_instrument <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign take = push && !full;

    tprp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .pattern_byte (pattern_byte),
        .op           (front_op)
    );

    tprp_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (2)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_op),
        .rd_en   (op_pop),
        .rd_data (queued_op),
        .full    (full),
        .empty   (op_empty)
    );

    tprp_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op       (queued_op),
        .op_valid (!op_empty),
        .res_full (res_full),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (back_res)
    );

    tprp_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .rd_en   (pop && !empty),
        .rd_data (out_res),
        .full    (res_full),
        .empty   (empty)
    );

    assign kind                 = out_res.kind;
    assign channel              = out_res.channel;
    assign note                 = out_res.note;
    assign instrument           = out_res.instrument;
    assign volume_command       = out_res.volume_command;
    assign effect_code          = out_res.effect_code;
    assign effect_param         = out_res.effect_param;
    assign event_bits           = out_res.event_bits;
    assign mask_upper           = out_res.mask_upper;
    assign row_update_mask      = out_res.row_update_mask;
    assign channel_out_of_range = out_res.channel_out_of_range;

endmodule
